// ===== sv/oxide_growth_and_stress_defines.svh =====
// oxide_growth_and_stress_defines.svh
// assertion macros for the oxide growth rtl; expects aclk and aresetn in scope
`ifndef OXIDE_GROWTH_AND_STRESS_DEFINES_SVH
`define OXIDE_GROWTH_AND_STRESS_DEFINES_SVH

// property that must hold in the same cycle as its trigger
`define OGS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// property that must hold in the cycle after its trigger
`define OGS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ogs_pkg.sv =====
`timescale 1ns / 1ps
// ogs_pkg: constants, tables and types of the oxide growth and stress pipeline
// no dependencies
package ogs_pkg;

    localparam int DIV_BITS   = 28;
    localparam int ROOT_STEPS = 8;
    localparam int SQRT_STEPS = 32;

    // configuration register index (byte address / 4)
    localparam logic CFG_IDX_WET = 1'b0;

    // activation energy over k*ln2, Q30 kelvin
    localparam logic [45:0] EK_DRY = 46'd35954090851739;
    localparam logic [45:0] EK_WET = 46'd36852943121421;
    // log2(B0) + 28, Q20
    localparam logic [25:0] LB_DRY = 26'd50573058;
    localparam logic [25:0] LB_WET = 26'd48819854;
    // (A + 2*X0)^2, Q30 um^2
    localparam logic [24:0] CSQ_DRY = 25'd30667140;
    localparam logic [24:0] CSQ_WET = 25'd9487583;
    // linear constant A, Q15 um
    localparam logic [12:0] LIN_DRY = 13'd5407;
    localparam logic [12:0] LIN_WET = 13'd2949;

    localparam logic [21:0] KELVIN_Q10 = 22'd279706;
    localparam logic [29:0] LN2_Q30    = 30'd744261118;
    localparam logic [63:0] FLOOR_Q16  = 64'd131;
    localparam logic [63:0] FAC_KNEE   = 64'd6554;
    localparam logic [16:0] FAC_ONE    = 17'd65536;

    // stress scaling: round(num / (2190 * 65536)) done as
    // ((num + half) >> 17) / 1095 with a reciprocal multiply
    localparam logic [47:0] STRESS_HALF = 48'd71761920;
    localparam logic [31:0] RECIP_1095  = 32'd4016480832;
    localparam logic [30:0] DIV_SMALL   = 31'd1095;
    localparam logic [20:0] SIG_MAX     = 21'd1048575;

    typedef struct packed {
        logic        wet;
        logic [31:0] dh225;
        logic [30:0] n7;
    } ctx_t;

    // 2^(2^-(idx+1)) in Q30
    function automatic logic [30:0] root_q30(input logic [2:0] idx);
        logic [30:0] r;
        unique case (idx)
            3'd0: r = 31'd1518500250;
            3'd1: r = 31'd1276901417;
            3'd2: r = 31'd1170923762;
            3'd3: r = 31'd1121280436;
            3'd4: r = 31'd1097253708;
            3'd5: r = 31'd1085434106;
            3'd6: r = 31'd1079572136;
            3'd7: r = 31'd1076653033;
            default: r = 31'd1073741824;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/oxide_growth_and_stress.sv =====
`timescale 1ns / 1ps
// oxide_growth_and_stress: linear-parabolic oxide growth and stress pipeline
// depends on ogs_pkg and oxide_growth_and_stress_defines.svh
//
// usage
//   s_ channel: one beat per sweep point, temperature and duration in tdata.
//   m_ channel: one beat per input beat, thickness and stress in tdata, in order.
//   apb port: register 0 (wet_atmosphere) picks dry or wet constants; write it
//   only while no beat is in flight.
// throughput: one beat per cycle while the skid register is empty; the chain
//   is a 28-stage restoring divider for Ea/kT, 8 root-multiply stages for 2^f
//   and a 32-stage square root, one step per register stage.
// reset: aresetn low clears all valid bits and selects dry constants.
// stall: with m_tready low the output register holds its beat and a skid
//   register takes one more; the pipeline then freezes and s_tready drops
//   until the skid drains. nothing is dropped or repeated.
module oxide_growth_and_stress (
    input  logic        aclk,
    input  logic        aresetn,
    // temperature_c [14:0], duration_hours [38:15], zero [39]
    input  logic [39:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // grown thickness [31:0], oxide_stress [52:32], zero [55:53]
    output logic [55:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ogs_pkg::*;

    logic adv;
    logic wet_reg;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == CFG_IDX_WET) ? {31'd0, wet_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wet_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == CFG_IDX_WET) begin
            wet_reg <= pwdata[0];
        end
    end

    // ---------------- input stage and divider ----------------
    logic              dv_valid_reg [0:DIV_BITS];
    logic [45:0]       dv_rem_reg   [0:DIV_BITS];
    logic [DIV_BITS-1:0] dv_q_reg   [0:DIV_BITS];
    logic [21:0]       dv_tk_reg    [0:DIV_BITS];
    ctx_t              dv_ctx_reg   [0:DIV_BITS];

    logic [14:0] in_tq;
    logic [23:0] in_dh;
    assign in_tq = s_tdata[14:0];
    assign in_dh = s_tdata[38:15];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_valid_reg[0] <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_rem_reg[0]       <= wet_reg ? EK_WET : EK_DRY;
            dv_q_reg[0]         <= '0;
            dv_tk_reg[0]        <= {1'b0, in_tq, 6'd0} + KELVIN_Q10;
            dv_ctx_reg[0].wet   <= wet_reg;
            dv_ctx_reg[0].dh225 <= 32'(in_dh) * 32'd225;
            dv_ctx_reg[0].n7    <= 31'd7 * (31'd203225200 - 31'(in_tq) * 31'd63);
        end
    end

    for (genvar j = 1; j <= DIV_BITS; j++) begin : g_div
        localparam int B = DIV_BITS - j;
        logic [49:0]         dsh;
        logic [49:0]         remx;
        logic                ge;
        logic [45:0]         rem_next;
        logic [DIV_BITS-1:0] q_next;

        always_comb begin
            dsh      = 50'(dv_tk_reg[j-1]) << B;
            remx     = 50'(dv_rem_reg[j-1]);
            ge       = (remx >= dsh);
            rem_next = ge ? 46'(remx - dsh) : dv_rem_reg[j-1];
            q_next   = dv_q_reg[j-1];
            q_next[B] = ge;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_valid_reg[j] <= 1'b0;
            end else if (adv) begin
                dv_valid_reg[j] <= dv_valid_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_rem_reg[j] <= rem_next;
                dv_q_reg[j]   <= q_next;
                dv_tk_reg[j]  <= dv_tk_reg[j-1];
                dv_ctx_reg[j] <= dv_ctx_reg[j-1];
            end
        end
    end

    // ---------------- exponent split and 2^f ----------------
    logic        pw_valid_reg [0:ROOT_STEPS];
    logic [30:0] pw_m_reg     [0:ROOT_STEPS];
    logic [19:0] pw_f_reg     [0:ROOT_STEPS];
    logic [8:0]  pw_n_reg     [0:ROOT_STEPS];
    logic [21:0] pw_e_reg     [0:ROOT_STEPS];
    logic [30:0] pw_c_reg     [0:ROOT_STEPS];
    ctx_t        pw_ctx_reg   [0:ROOT_STEPS];

    logic [28:0] u_next;
    always_comb begin
        u_next = 29'(dv_ctx_reg[DIV_BITS].wet ? LB_WET : LB_DRY) + 29'(1 << 28)
               - 29'(dv_q_reg[DIV_BITS]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pw_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            pw_valid_reg[0] <= dv_valid_reg[DIV_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pw_m_reg[0]   <= 31'(1 << 30);
            pw_f_reg[0]   <= u_next[19:0];
            pw_n_reg[0]   <= u_next[28:20];
            pw_e_reg[0]   <= '0;
            pw_c_reg[0]   <= '0;
            pw_ctx_reg[0] <= dv_ctx_reg[DIV_BITS];
        end
    end

    for (genvar p = 1; p <= ROOT_STEPS; p++) begin : g_pow
        localparam int FB = 20 - p;
        logic [30:0] m_next;
        logic [21:0] e_next;
        logic [30:0] c_next;

        always_comb begin
            m_next = pw_f_reg[p-1][FB]
                   ? 31'((62'(pw_m_reg[p-1]) * 62'(root_q30(3'(p - 1)))) >> 30)
                   : pw_m_reg[p-1];
            e_next = pw_e_reg[p-1];
            c_next = pw_c_reg[p-1];
            // low fraction bits go through 1 + e + e^2/2
            if (p == 1) begin
                e_next = 22'((42'(pw_f_reg[p-1][11:0]) * 42'(LN2_Q30)) >> 20);
            end
            if (p == 2) begin
                c_next = 31'(1 << 30) + 31'(pw_e_reg[p-1])
                       + 31'((44'(pw_e_reg[p-1]) * 44'(pw_e_reg[p-1])) >> 31);
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pw_valid_reg[p] <= 1'b0;
            end else if (adv) begin
                pw_valid_reg[p] <= pw_valid_reg[p-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                pw_m_reg[p]   <= m_next;
                pw_f_reg[p]   <= pw_f_reg[p-1];
                pw_n_reg[p]   <= pw_n_reg[p-1];
                pw_e_reg[p]   <= e_next;
                pw_c_reg[p]   <= c_next;
                pw_ctx_reg[p] <= pw_ctx_reg[p-1];
            end
        end
    end

    // ---------------- growth term and normalization ----------------
    logic        mc_valid_reg, pr_valid_reg, lz_valid_reg, s1_valid_reg;
    logic [31:0] mc_p2_reg;
    logic [8:0]  mc_n_reg, pr_n_reg;
    ctx_t        mc_ctx_reg, pr_ctx_reg, lz_ctx_reg, s1_ctx_reg;
    logic [63:0] pr_prod_reg, lz_prod_reg, s1_prod_reg;
    logic [6:0]  lz_len_reg;
    logic signed [10:0] lz_sh_reg;
    logic        s1_tleft_reg, s1_tzero_reg, s1_bzero_reg;
    logic [5:0]  s1_tamt_reg, s1_bsh_reg;
    logic [6:0]  s1_k_reg;

    logic [6:0]  len_next;
    logic signed [10:0] sh_next;
    logic        tleft_next, tzero_next, bzero_next;
    logic [5:0]  tamt_next, bsh_next;
    logic [6:0]  k_next;

    always_comb begin
        len_next = '0;
        for (int i = 0; i < 64; i++) begin
            if (pr_prod_reg[i]) begin
                len_next = 7'(i + 1);
            end
        end
        sh_next = $signed({2'b00, pr_n_reg}) - 11'sd286;
    end

    // pick k so that the growth term shifted left stays below 2^62
    always_comb begin
        logic [8:0] neg;
        logic [8:0] shp;
        logic [8:0] m62;
        logic [8:0] kk;
        logic signed [10:0] amt;
        neg        = '0;
        shp        = '0;
        m62        = '0;
        kk         = '0;
        amt        = '0;
        tleft_next = 1'b0;
        tzero_next = 1'b0;
        tamt_next  = '0;
        k_next     = '0;
        if (lz_sh_reg <= 11'sd0) begin
            neg        = 9'(-lz_sh_reg);
            tzero_next = (neg >= 9'd64);
            tamt_next  = neg[5:0];
        end else begin
            shp = 9'(lz_sh_reg);
            m62 = (lz_len_reg >= 7'd62) ? 9'd0 : 9'(7'd62 - lz_len_reg);
            kk  = (shp > m62) ? ((shp - m62 + 9'd1) >> 1) : 9'd0;
            amt = $signed({2'b00, shp}) - $signed({1'b0, kk, 1'b0});
            if (amt < 11'sd0) begin
                tamt_next = 6'd1;
            end else begin
                tleft_next = 1'b1;
                tamt_next  = amt[5:0];
            end
            k_next = kk[6:0];
        end
        bzero_next = (k_next >= 7'd32);
        bsh_next   = {k_next[4:0], 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mc_valid_reg <= 1'b0;
            pr_valid_reg <= 1'b0;
            lz_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
        end else if (adv) begin
            mc_valid_reg <= pw_valid_reg[ROOT_STEPS];
            pr_valid_reg <= mc_valid_reg;
            lz_valid_reg <= pr_valid_reg;
            s1_valid_reg <= lz_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            mc_p2_reg    <= 32'((62'(pw_m_reg[ROOT_STEPS]) * 62'(pw_c_reg[ROOT_STEPS])) >> 30);
            mc_n_reg     <= pw_n_reg[ROOT_STEPS];
            mc_ctx_reg   <= pw_ctx_reg[ROOT_STEPS];
            pr_prod_reg  <= 64'(mc_ctx_reg.dh225) * 64'(mc_p2_reg);
            pr_n_reg     <= mc_n_reg;
            pr_ctx_reg   <= mc_ctx_reg;
            lz_prod_reg  <= pr_prod_reg;
            lz_len_reg   <= len_next;
            lz_sh_reg    <= sh_next;
            lz_ctx_reg   <= pr_ctx_reg;
            s1_prod_reg  <= lz_prod_reg;
            s1_tleft_reg <= tleft_next;
            s1_tzero_reg <= tzero_next;
            s1_tamt_reg  <= tamt_next;
            s1_bzero_reg <= bzero_next;
            s1_bsh_reg   <= bsh_next;
            s1_k_reg     <= k_next;
            s1_ctx_reg   <= lz_ctx_reg;
        end
    end

    // ---------------- radicand and square root ----------------
    logic        sq_valid_reg [0:SQRT_STEPS];
    logic [63:0] sq_rem_reg   [0:SQRT_STEPS];
    logic [63:0] sq_root_reg  [0:SQRT_STEPS];
    logic [6:0]  sq_k_reg     [0:SQRT_STEPS];
    ctx_t        sq_ctx_reg   [0:SQRT_STEPS];

    logic [63:0] term_next, base_next;
    always_comb begin
        if (s1_tzero_reg) begin
            term_next = '0;
        end else if (s1_tleft_reg) begin
            term_next = s1_prod_reg << s1_tamt_reg;
        end else begin
            term_next = s1_prod_reg >> s1_tamt_reg;
        end
        base_next = s1_bzero_reg ? 64'd0
                  : (64'(s1_ctx_reg.wet ? CSQ_WET : CSQ_DRY) >> s1_bsh_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg[0] <= 1'b0;
        end else if (adv) begin
            sq_valid_reg[0] <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sq_rem_reg[0]  <= base_next + term_next;
            sq_root_reg[0] <= '0;
            sq_k_reg[0]    <= s1_k_reg;
            sq_ctx_reg[0]  <= s1_ctx_reg;
        end
    end

    for (genvar j = 1; j <= SQRT_STEPS; j++) begin : g_sqrt
        localparam int BP = 62 - 2 * (j - 1);
        logic [63:0] bitv;
        logic [63:0] trial;
        logic [63:0] rem_next;
        logic [63:0] root_next;

        always_comb begin
            bitv  = 64'd1 << BP;
            trial = sq_root_reg[j-1] + bitv;
            if (sq_rem_reg[j-1] >= trial) begin
                rem_next  = sq_rem_reg[j-1] - trial;
                root_next = (sq_root_reg[j-1] >> 1) + bitv;
            end else begin
                rem_next  = sq_rem_reg[j-1];
                root_next = sq_root_reg[j-1] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_valid_reg[j] <= 1'b0;
            end else if (adv) begin
                sq_valid_reg[j] <= sq_valid_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                sq_rem_reg[j]  <= rem_next;
                sq_root_reg[j] <= root_next;
                sq_k_reg[j]    <= sq_k_reg[j-1];
                sq_ctx_reg[j]  <= sq_ctx_reg[j-1];
            end
        end
    end

    // ---------------- thickness and stress ----------------
    logic        rt_valid_reg, xq_valid_reg;
    logic [63:0] rt_root_reg, xq_x_reg;
    ctx_t        rt_ctx_reg, xq_ctx_reg;
    logic        st1_valid_reg, st2_valid_reg, st3_valid_reg, st4_valid_reg, st5_valid_reg;
    logic [31:0] st1_thick_reg, st2_thick_reg, st3_thick_reg, st4_thick_reg, st5_thick_reg;
    logic [16:0] st1_fac_reg;
    logic [30:0] st1_n7_reg;
    logic [47:0] st2_num_reg;
    logic [29:0] st3_b_reg, st4_b_reg;
    logic [20:0] st4_q0_reg;
    logic [20:0] st5_sig_reg;

    logic [63:0] lin_w, xd_w, xq_next;
    logic [31:0] thick_next;
    logic [16:0] fac_next;
    logic [16:0] fac_lin;
    logic [47:0] rnd_sum;
    logic [30:0] rem_small;
    logic [20:0] sig_raw;

    always_comb begin
        lin_w   = 64'(rt_ctx_reg.wet ? LIN_WET : LIN_DRY);
        xd_w    = (rt_root_reg > lin_w) ? rt_root_reg - lin_w : 64'd0;
        // never thinner than the 2 nm native layer
        xq_next = (xd_w < FLOOR_Q16) ? FLOOR_Q16 : xd_w;

        thick_next = (|xq_x_reg[63:32]) ? 32'hFFFF_FFFF : xq_x_reg[31:0];
        fac_lin    = 17'(xq_x_reg[12:0]) * 17'd10;
        if (xq_x_reg >= FAC_KNEE) begin
            fac_next = FAC_ONE;
        end else if (fac_lin > FAC_ONE) begin
            fac_next = FAC_ONE;
        end else begin
            fac_next = fac_lin;
        end

        rnd_sum   = st2_num_reg + STRESS_HALF;
        rem_small = 31'(st4_b_reg) - 31'(st4_q0_reg) * DIV_SMALL;
        // reciprocal estimate is exact or one low
        sig_raw   = (rem_small >= DIV_SMALL) ? st4_q0_reg + 21'd1 : st4_q0_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rt_valid_reg  <= 1'b0;
            xq_valid_reg  <= 1'b0;
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
            st4_valid_reg <= 1'b0;
            st5_valid_reg <= 1'b0;
        end else if (adv) begin
            rt_valid_reg  <= sq_valid_reg[SQRT_STEPS];
            xq_valid_reg  <= rt_valid_reg;
            st1_valid_reg <= xq_valid_reg;
            st2_valid_reg <= st1_valid_reg;
            st3_valid_reg <= st2_valid_reg;
            st4_valid_reg <= st3_valid_reg;
            st5_valid_reg <= st4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rt_root_reg   <= (sq_k_reg[SQRT_STEPS] >= 7'd31) ? '1
                           : (sq_root_reg[SQRT_STEPS] << sq_k_reg[SQRT_STEPS][4:0]);
            rt_ctx_reg    <= sq_ctx_reg[SQRT_STEPS];
            xq_x_reg      <= xq_next;
            xq_ctx_reg    <= rt_ctx_reg;
            st1_thick_reg <= thick_next;
            st1_fac_reg   <= fac_next;
            st1_n7_reg    <= xq_ctx_reg.n7;
            st2_thick_reg <= st1_thick_reg;
            st2_num_reg   <= 48'(st1_n7_reg) * 48'(st1_fac_reg);
            st3_thick_reg <= st2_thick_reg;
            st3_b_reg     <= 30'(rnd_sum >> 17);
            st4_thick_reg <= st3_thick_reg;
            st4_b_reg     <= st3_b_reg;
            st4_q0_reg    <= 21'((63'(st3_b_reg) * 63'(RECIP_1095)) >> 42);
            st5_thick_reg <= st4_thick_reg;
            st5_sig_reg   <= (sig_raw > SIG_MAX) ? SIG_MAX : sig_raw;
        end
    end

    // ---------------- output register and skid ----------------
    logic        out_valid_reg, skid_valid_reg;
    logic [55:0] out_data_reg, skid_data_reg;
    logic [55:0] pipe_word;
    logic        take, push;

    assign adv       = ~skid_valid_reg;
    assign s_tready  = adv;
    assign pipe_word = {3'd0, st5_sig_reg, st5_thick_reg};
    assign take      = m_tready | ~out_valid_reg;
    assign push      = adv & st5_valid_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (take) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : pipe_word;
        end
        if (!take && push) begin
            skid_data_reg <= pipe_word;
        end
    end

    // ---------------- assertions ----------------
`include "oxide_growth_and_stress_defines.svh"

    `OGS_ASSERT_SAME(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid holds a beat while the output register is empty")
    `OGS_ASSERT_NEXT(a_stall_fills_skid, out_valid_reg && !m_tready && push,
        skid_valid_reg, "beat leaving the pipeline under stall was not caught")
    `OGS_ASSERT_SAME(a_thick_floor, out_valid_reg,
        out_data_reg[31:0] >= FLOOR_Q16[31:0], "thickness below the native layer")
    `OGS_ASSERT_SAME(a_div_rem, dv_valid_reg[DIV_BITS],
        dv_rem_reg[DIV_BITS] < 46'(dv_tk_reg[DIV_BITS]), "divider remainder not reduced")

endmodule
